[design/cilp_pkg.sv]
// Shared types, codes and the character classifier for the C integer literal parser.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package cilp_pkg;

  // Depth of the queue between the front and the back
  localparam int QUEUE_DEPTH = 4;

  localparam int CHAR_W   = 8;
  localparam int VALUE_W  = 64;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;
  localparam int RADIX_W  = 2;
  localparam int PREFIX_W = 2;
  localparam int OUT_W    = 80;   // 77 field bits padded to whole bytes

  // Digit limits per radix
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 7'd127;
  localparam logic [COUNT_W-1:0] BIN_MAX_DIGITS = 7'd64;
  localparam logic [COUNT_W-1:0] OCT_MAX_DIGITS = 7'd22;
  localparam logic [COUNT_W-1:0] DEC_MAX_DIGITS = 7'd20;
  localparam logic [COUNT_W-1:0] HEX_MAX_DIGITS = 7'd16;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_INT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 2'd2;

  // Prefix lengths
  localparam logic [PREFIX_W-1:0] PFX_NONE = 2'd0;
  localparam logic [PREFIX_W-1:0] PFX_OCT  = 2'd1;
  localparam logic [PREFIX_W-1:0] PFX_TWO  = 2'd2;

  typedef enum logic [1:0] {
    PH_START      = 2'd0,
    PH_AFTER_ZERO = 2'd1,
    PH_DIGITS     = 2'd2,
    PH_DONE       = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    RX_BIN = 2'd0,
    RX_OCT = 2'd1,
    RX_DEC = 2'd2,
    RX_HEX = 2'd3
  } radix_t;

  typedef enum logic [1:0] {
    VD_EVAL   = 2'd0,
    VD_REJECT = 2'd1,
    VD_ZERO   = 2'd2
  } verdict_t;

  // Classified character, as carried from front to back
  typedef struct packed {
    logic       last;
    logic       is_zero;
    logic       is_x;
    logic       is_b;
    logic       is_dot;
    logic       is_hex;
    logic       in_bin;
    logic       in_oct;
    logic       in_dec;
    logic [3:0] digit;
  } char_class_t;

  function automatic char_class_t classify(input logic [CHAR_W-1:0] c, input logic last);
    char_class_t r;
    logic num, lower, upper;
    num   = (c >= 8'h30) && (c <= 8'h39);
    lower = (c >= 8'h61) && (c <= 8'h66);
    upper = (c >= 8'h41) && (c <= 8'h46);
    r.last    = last;
    r.is_zero = (c == 8'h30);
    r.is_x    = (c == 8'h78) || (c == 8'h58);
    r.is_b    = (c == 8'h62) || (c == 8'h42);
    r.is_dot  = (c == 8'h2e);
    r.is_hex  = num || lower || upper;
    r.in_bin  = (c == 8'h30) || (c == 8'h31);
    r.in_oct  = (c >= 8'h30) && (c <= 8'h37);
    r.in_dec  = num;
    if (num) begin
      r.digit = c[3:0];
    end else begin
      // 'a'..'f' and 'A'..'F' share the low three bits: 1..6 -> 10..15
      r.digit = 4'd9 + {1'b0, c[2:0]};
    end
    return r;
  endfunction

endpackage

[design/cilp_front.sv]
// Front stage: accepts characters and registers their classification.
// Depends on cilp_pkg.
`timescale 1ns / 1ps

module cilp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cilp_pkg::CHAR_W-1:0] in_char,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cilp_pkg::char_class_t      out_class
);

  logic                  stage_valid;
  cilp_pkg::char_class_t stage_class;

  // Stage takes a new item when empty or draining this cycle
  assign in_ready  = !stage_valid || out_ready;
  assign out_valid = stage_valid;
  assign out_class = stage_class;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Classified payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_class <= cilp_pkg::classify(in_char, in_last);
    end
  end

endmodule

[design/cilp_queue.sv]
// Short queue of classified items between front and back.
// Depends on cilp_pkg.
`timescale 1ns / 1ps

module cilp_queue #(
  parameter int DEPTH = cilp_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cilp_pkg::char_class_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cilp_pkg::char_class_t out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cilp_pkg::char_class_t entries [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entries[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= in_data;
    end
  end

endmodule

[design/cilp_back.sv]
// Back part: literal state machine, value accumulator, range check and result register.
// Depends on cilp_pkg.
`timescale 1ns / 1ps

module cilp_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cilp_pkg::char_class_t             in_class,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [cilp_pkg::STATUS_W-1:0]     res_status,
  output logic [cilp_pkg::RADIX_W-1:0]      res_radix,
  output logic [cilp_pkg::VALUE_W-1:0]      res_value,
  output logic [cilp_pkg::PREFIX_W-1:0]     res_prefix,
  output logic [cilp_pkg::COUNT_W-1:0]      res_count
);

  localparam int VW = cilp_pkg::VALUE_W;
  localparam int CW = cilp_pkg::COUNT_W;

  logic reject_float_like;

  cilp_pkg::phase_t   phase, phase_next;
  cilp_pkg::radix_t   radix, radix_next;
  cilp_pkg::verdict_t verdict, verdict_next;
  logic [VW-1:0]      value_acc, value_next;
  logic [CW-1:0]      count_acc, count_next;
  logic               first_low, first_low_next;
  logic               carry_seen, carry_next;

  logic               do_scan;
  logic [VW+3:0]      dec_sum;
  logic               fire;
  logic               too_big;
  cilp_pkg::verdict_t final_vd;

  logic [cilp_pkg::STATUS_W-1:0] st_next;
  logic [cilp_pkg::RADIX_W-1:0]  rx_next;
  logic [VW-1:0]                 val_next;
  logic [cilp_pkg::PREFIX_W-1:0] pfx_next;
  logic [CW-1:0]                 cnt_next;

  // An item that ends a literal needs a free result register
  assign in_ready = !in_class.last || !res_valid || res_ready;
  assign fire     = in_valid && in_ready;

  // Times ten plus digit, with the carry above 64 bits kept
  assign dec_sum = ({4'b0, value_acc} << 3) + ({4'b0, value_acc} << 1)
                 + (VW+4)'(in_class.digit);

  // Next state of the literal scan
  always_comb begin
    phase_next     = phase;
    radix_next     = radix;
    verdict_next   = verdict;
    value_next     = value_acc;
    count_next     = count_acc;
    first_low_next = first_low;
    carry_next     = carry_seen;
    do_scan        = 1'b0;

    unique case (phase)
      cilp_pkg::PH_START: begin
        if (in_class.is_zero) begin
          phase_next = cilp_pkg::PH_AFTER_ZERO;
        end else begin
          radix_next = cilp_pkg::RX_DEC;
          phase_next = cilp_pkg::PH_DIGITS;
          do_scan    = 1'b1;
        end
      end
      cilp_pkg::PH_AFTER_ZERO: begin
        if (in_class.is_x || in_class.is_b) begin
          if (in_class.last) begin
            verdict_next = cilp_pkg::VD_ZERO;
            phase_next   = cilp_pkg::PH_DONE;
          end else begin
            radix_next = in_class.is_x ? cilp_pkg::RX_HEX : cilp_pkg::RX_BIN;
            phase_next = cilp_pkg::PH_DIGITS;
          end
        end else if (in_class.in_oct) begin
          radix_next = cilp_pkg::RX_OCT;
          phase_next = cilp_pkg::PH_DIGITS;
          do_scan    = 1'b1;
        end else if (reject_float_like && in_class.is_dot) begin
          verdict_next = cilp_pkg::VD_REJECT;
          phase_next   = cilp_pkg::PH_DONE;
        end else begin
          verdict_next = cilp_pkg::VD_ZERO;
          phase_next   = cilp_pkg::PH_DONE;
        end
      end
      cilp_pkg::PH_DIGITS: begin
        do_scan = 1'b1;
      end
      cilp_pkg::PH_DONE: begin
        phase_next = phase;
      end
      default: begin
        phase_next = phase;
      end
    endcase

    // One character of the digit run
    if (do_scan) begin
      logic in_rx;
      in_rx = 1'b0;
      case (radix_next)
        cilp_pkg::RX_BIN: in_rx = in_class.in_bin;
        cilp_pkg::RX_OCT: in_rx = in_class.in_oct;
        cilp_pkg::RX_DEC: in_rx = in_class.in_dec;
        default:          in_rx = in_class.is_hex;
      endcase
      if (reject_float_like && in_class.is_dot) begin
        verdict_next = cilp_pkg::VD_REJECT;
        phase_next   = cilp_pkg::PH_DONE;
      end else if (in_rx) begin
        if (count_acc == '0) begin
          first_low_next = in_class.in_bin;
        end
        case (radix_next)
          cilp_pkg::RX_BIN: value_next = {value_acc[VW-2:0], in_class.digit[0]};
          cilp_pkg::RX_OCT: value_next = {value_acc[VW-4:0], in_class.digit[2:0]};
          cilp_pkg::RX_HEX: value_next = {value_acc[VW-5:0], in_class.digit};
          default: begin
            value_next = dec_sum[VW-1:0];
            if (dec_sum[VW+3:VW] != 4'd0) begin
              carry_next = 1'b1;
            end
          end
        endcase
        if (count_acc != cilp_pkg::COUNT_MAX) begin
          count_next = count_acc + 1'b1;
        end
      end else if (in_class.is_hex) begin
        verdict_next = cilp_pkg::VD_REJECT;
        phase_next   = cilp_pkg::PH_DONE;
      end else begin
        verdict_next = (count_acc == '0) ? cilp_pkg::VD_REJECT : cilp_pkg::VD_EVAL;
        phase_next   = cilp_pkg::PH_DONE;
      end
    end
  end

  // Range check and result fields
  always_comb begin
    case (radix_next)
      cilp_pkg::RX_BIN: too_big = count_next > cilp_pkg::BIN_MAX_DIGITS;
      cilp_pkg::RX_OCT: too_big = (count_next > cilp_pkg::OCT_MAX_DIGITS)
                               || ((count_next == cilp_pkg::OCT_MAX_DIGITS) && !first_low_next);
      cilp_pkg::RX_DEC: too_big = (count_next > cilp_pkg::DEC_MAX_DIGITS) || carry_next;
      default:          too_big = count_next > cilp_pkg::HEX_MAX_DIGITS;
    endcase

    final_vd = verdict_next;
    if (phase_next == cilp_pkg::PH_AFTER_ZERO) begin
      final_vd = cilp_pkg::VD_ZERO;
    end
    if (final_vd == cilp_pkg::VD_EVAL && count_next == '0) begin
      final_vd = cilp_pkg::VD_REJECT;
    end

    unique case (final_vd)
      cilp_pkg::VD_ZERO: begin
        st_next  = cilp_pkg::ST_OK;
        rx_next  = cilp_pkg::RX_DEC;
        val_next = '0;
        pfx_next = cilp_pkg::PFX_NONE;
        cnt_next = CW'(1);
      end
      cilp_pkg::VD_REJECT: begin
        st_next  = cilp_pkg::ST_NOT_INT;
        rx_next  = cilp_pkg::RX_BIN;
        val_next = '0;
        pfx_next = cilp_pkg::PFX_NONE;
        cnt_next = '0;
      end
      default: begin
        st_next  = too_big ? cilp_pkg::ST_TOO_BIG : cilp_pkg::ST_OK;
        rx_next  = radix_next;
        val_next = too_big ? '0 : value_next;
        case (radix_next)
          cilp_pkg::RX_DEC: pfx_next = cilp_pkg::PFX_NONE;
          cilp_pkg::RX_OCT: pfx_next = cilp_pkg::PFX_OCT;
          default:          pfx_next = cilp_pkg::PFX_TWO;
        endcase
        cnt_next = count_next;
      end
    endcase
  end

  // Option register
  always_ff @(posedge clk) begin
    if (rst) begin
      reject_float_like <= 1'b0;
    end else if (cfg_we) begin
      reject_float_like <= cfg_wdata;
    end
  end

  // Scan state; a literal's final item returns it to the start
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= cilp_pkg::PH_START;
      radix      <= cilp_pkg::RX_DEC;
      verdict    <= cilp_pkg::VD_EVAL;
      value_acc  <= '0;
      count_acc  <= '0;
      first_low  <= 1'b0;
      carry_seen <= 1'b0;
    end else if (fire) begin
      if (in_class.last) begin
        phase      <= cilp_pkg::PH_START;
        radix      <= cilp_pkg::RX_DEC;
        verdict    <= cilp_pkg::VD_EVAL;
        value_acc  <= '0;
        count_acc  <= '0;
        first_low  <= 1'b0;
        carry_seen <= 1'b0;
      end else begin
        phase      <= phase_next;
        radix      <= radix_next;
        verdict    <= verdict_next;
        value_acc  <= value_next;
        count_acc  <= count_next;
        first_low  <= first_low_next;
        carry_seen <= carry_next;
      end
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && in_class.last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire && in_class.last) begin
      res_status <= st_next;
      res_radix  <= rx_next;
      res_value  <= val_next;
      res_prefix <= pfx_next;
      res_count  <= cnt_next;
    end
  end

endmodule

[design/c_integer_literal_parser.sv]
// C integer literal parser: one character per item, result on the last one.
// Throughput: one character per cycle, except while a last character waits for a result register not yet taken.
// Result path: a last character passes through the front classify register, then a queue entry,
// then the result register, in that order.
// Reset: synchronous rst clears the front valid, queue, scan state, result valid and the option bit.
// Depends on cilp_pkg, cilp_front, cilp_queue and cilp_back.
`timescale 1ns / 1ps

module c_integer_literal_parser #(
  parameter int QUEUE_DEPTH = cilp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,     // reject_float_like
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // [7:0] char_in
  input  logic        s_tlast,       // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata        // [1:0] status, [3:2] radix_code, [67:4] value,
                                     // [69:68] prefix_length, [76:70] digit_count, zero pad
);

  logic                  fr_valid;
  logic                  fr_ready;
  cilp_pkg::char_class_t fr_class;
  logic                  q_valid;
  logic                  q_ready;
  cilp_pkg::char_class_t q_class;

  logic [cilp_pkg::STATUS_W-1:0] res_status;
  logic [cilp_pkg::RADIX_W-1:0]  res_radix;
  logic [cilp_pkg::VALUE_W-1:0]  res_value;
  logic [cilp_pkg::PREFIX_W-1:0] res_prefix;
  logic [cilp_pkg::COUNT_W-1:0]  res_count;

  // Classify incoming characters
  cilp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_char   (s_tdata),
    .in_last   (s_tlast),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_class (fr_class)
  );

  // Decouple front from back
  cilp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_class),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_class)
  );

  // Scan, accumulate and report
  cilp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_class   (q_class),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_status (res_status),
    .res_radix  (res_radix),
    .res_value  (res_value),
    .res_prefix (res_prefix),
    .res_count  (res_count)
  );

  // Pack result fields, lowest first
  assign m_tdata = {3'b000, res_count, res_prefix, res_value, res_radix, res_status};

endmodule

[sim/tb_c_integer_literal_parser.sv]
// Self-checking testbench for c_integer_literal_parser: streams literal text in, checks results.
// Depends on cilp_pkg and the design files; holds its own predictor of the parser.
`timescale 1ns / 1ps

module tb_c_integer_literal_parser;

  localparam int          HALF_PERIOD  = 2;
  localparam int          RESET_CYCLES = 12;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DEAD_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          ITEM_TARGET  = 1300;
  localparam int          NUM_PHASES   = 6;
  localparam logic [63:0] WORD_MAX     = '1;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;     // [7:0] char_in
  logic        s_tlast;     // last
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;     // [1:0] status, [3:2] radix_code, [67:4] value,
                            // [69:68] prefix_length, [76:70] digit_count

  // One expected result item
  typedef struct {
    logic [1:0]       status;
    cilp_pkg::radix_t radix;
    logic [63:0]      value;
    logic [1:0]       prefix;
    logic [6:0]       count;
  } literal_result_t;

  // Predicts parser results and checks them in order
  class literal_predictor;
    bit                 reject_dots;
    cilp_pkg::phase_t   phase;
    cilp_pkg::radix_t   radix;
    logic [63:0]        acc;
    logic [6:0]         count;
    bit                 first_low;
    bit                 carry;
    cilp_pkg::verdict_t verdict;
    literal_result_t    expected_results[$];
    int                 mismatches;
    int                 results_seen;

    function new();
      reject_dots  = 1'b0;
      mismatches   = 0;
      results_seen = 0;
      clear();
    endfunction

    function void clear();
      phase     = cilp_pkg::PH_START;
      radix     = cilp_pkg::RX_DEC;
      acc       = '0;
      count     = '0;
      first_low = 1'b0;
      carry     = 1'b0;
      verdict   = cilp_pkg::VD_EVAL;
    endfunction

    function bit hex_char(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    // Only called for hex characters
    function logic [3:0] digit_of(logic [7:0] c);
      if (c <= "9") return 4'(c - "0");
      if (c >= "a") return 4'(c - "a" + 8'd10);
      return 4'(c - "A" + 8'd10);
    endfunction

    function bit fits_radix(logic [7:0] c);
      case (radix)
        cilp_pkg::RX_BIN: return c == "0" || c == "1";
        cilp_pkg::RX_OCT: return c >= "0" && c <= "7";
        cilp_pkg::RX_DEC: return c >= "0" && c <= "9";
        default:          return hex_char(c);
      endcase
    endfunction

    function void close(cilp_pkg::verdict_t v);
      verdict = v;
      phase   = cilp_pkg::PH_DONE;
    endfunction

    // One character of the digit run
    function void scan(logic [7:0] c);
      logic [63:0] d;
      if (reject_dots && c == ".") begin
        close(cilp_pkg::VD_REJECT);
        return;
      end
      if (fits_radix(c)) begin
        d = 64'(digit_of(c));
        if (count == 0) first_low = (c <= "1");
        case (radix)
          cilp_pkg::RX_BIN: acc = (acc << 1) | d;
          cilp_pkg::RX_OCT: acc = (acc << 3) | d;
          cilp_pkg::RX_HEX: acc = (acc << 4) | d;
          default: begin
            if (acc > (WORD_MAX - d) / 64'd10) carry = 1'b1;
            acc = acc * 64'd10 + d;
          end
        endcase
        if (count < cilp_pkg::COUNT_MAX) count++;
        return;
      end
      // hex digit outside the radix, or an empty run, rejects
      if (hex_char(c) || count == 0) begin
        close(cilp_pkg::VD_REJECT);
      end else begin
        close(cilp_pkg::VD_EVAL);
      end
    endfunction

    function bit over_limit();
      case (radix)
        cilp_pkg::RX_BIN: return count > cilp_pkg::BIN_MAX_DIGITS;
        cilp_pkg::RX_OCT: return count > cilp_pkg::OCT_MAX_DIGITS
                              || (count == cilp_pkg::OCT_MAX_DIGITS && !first_low);
        cilp_pkg::RX_DEC: return count > cilp_pkg::DEC_MAX_DIGITS || carry;
        default:          return count > cilp_pkg::HEX_MAX_DIGITS;
      endcase
    endfunction

    // Accepted input item
    function void note_char(logic [7:0] c, logic is_last);
      cilp_pkg::verdict_t v;
      literal_result_t    e;
      bit                 big;
      case (phase)
        cilp_pkg::PH_START: begin
          if (c == "0") begin
            phase = cilp_pkg::PH_AFTER_ZERO;
          end else begin
            radix = cilp_pkg::RX_DEC;
            phase = cilp_pkg::PH_DIGITS;
            scan(c);
          end
        end
        cilp_pkg::PH_AFTER_ZERO: begin
          if (c == "x" || c == "X" || c == "b" || c == "B") begin
            if (is_last) begin
              close(cilp_pkg::VD_ZERO);
            end else begin
              if (c == "x" || c == "X") radix = cilp_pkg::RX_HEX;
              else radix = cilp_pkg::RX_BIN;
              phase = cilp_pkg::PH_DIGITS;
            end
          end else if (c >= "0" && c <= "7") begin
            radix = cilp_pkg::RX_OCT;
            phase = cilp_pkg::PH_DIGITS;
            scan(c);
          end else if (reject_dots && c == ".") begin
            close(cilp_pkg::VD_REJECT);
          end else begin
            close(cilp_pkg::VD_ZERO);
          end
        end
        cilp_pkg::PH_DIGITS: scan(c);
        default: ;
      endcase
      if (!is_last) return;

      v = verdict;
      if (phase == cilp_pkg::PH_AFTER_ZERO) v = cilp_pkg::VD_ZERO;
      if (v == cilp_pkg::VD_EVAL && count == 0) v = cilp_pkg::VD_REJECT;
      if (v == cilp_pkg::VD_ZERO) begin
        e.status = cilp_pkg::ST_OK;
        e.radix  = cilp_pkg::RX_DEC;
        e.value  = '0;
        e.prefix = cilp_pkg::PFX_NONE;
        e.count  = 7'd1;
      end else if (v == cilp_pkg::VD_REJECT) begin
        e.status = cilp_pkg::ST_NOT_INT;
        e.radix  = cilp_pkg::RX_BIN;
        e.value  = '0;
        e.prefix = cilp_pkg::PFX_NONE;
        e.count  = '0;
      end else begin
        big      = over_limit();
        e.status = big ? cilp_pkg::ST_TOO_BIG : cilp_pkg::ST_OK;
        e.radix  = radix;
        e.value  = big ? 64'd0 : acc;
        if (radix == cilp_pkg::RX_DEC) e.prefix = cilp_pkg::PFX_NONE;
        else if (radix == cilp_pkg::RX_OCT) e.prefix = cilp_pkg::PFX_OCT;
        else e.prefix = cilp_pkg::PFX_TWO;
        e.count  = count;
      end
      expected_results.push_back(e);
      clear();
    endfunction

    // Accepted result item
    function void check_result(logic [79:0] d);
      literal_result_t e;
      if (expected_results.size() == 0) begin
        $error("result item with no literal pending: %h", d);
        mismatches++;
        return;
      end
      e = expected_results.pop_front();
      results_seen++;
      if (d[1:0] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, d[1:0]);
        mismatches++;
      end
      if (d[3:2] !== e.radix) begin
        $error("radix_code: expected %0d, got %0d", e.radix, d[3:2]);
        mismatches++;
      end
      if (d[67:4] !== e.value) begin
        $error("value: expected %0d, got %0d", e.value, d[67:4]);
        mismatches++;
      end
      if (d[69:68] !== e.prefix) begin
        $error("prefix_length: expected %0d, got %0d", e.prefix, d[69:68]);
        mismatches++;
      end
      if (d[76:70] !== e.count) begin
        $error("digit_count: expected %0d, got %0d", e.count, d[76:70]);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  literal_predictor pred = new();

  logic [7:0] text[$];
  bit         quiet       = 1'b0;
  bit         stall_req   = 1'b0;
  bit         stall_taken = 1'b0;
  bit         short_mode  = 1'b0;
  int         items_sent    = 0;
  int         literals_sent = 0;
  int         option_writes = 0;
  int         dead_cycles   = 0;

  c_integer_literal_parser uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Result side: random stalls, one long hold when asked
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req && !stall_taken) begin
        stall_taken = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= quiet || ($urandom_range(0, 99) >= 25);
    end
  end

  // Result checking
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) pred.check_result(m_tdata);
  end

  // Cycles with no handshake on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) dead_cycles <= 0;
    else dead_cycles <= dead_cycles + 1;
  end

  initial begin
    while (dead_cycles < DEAD_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // Drive one character, with random gaps before it
  task automatic send_item(logic [7:0] c, logic is_last);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 25) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    pred.note_char(c, is_last);
    items_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text.size(); i++) send_item(text[i], i == text.size() - 1);
    literals_sent++;
  endtask

  task automatic send_string(string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text();
  endtask

  // Drop valid, let all results drain, then allow for work in flight
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pred.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_option(bit v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    pred.reject_dots = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    option_writes++;
  endtask

  function automatic logic [7:0] digit_char(cilp_pkg::radix_t r);
    int v;
    case (r)
      cilp_pkg::RX_BIN: v = $urandom_range(0, 1);
      cilp_pkg::RX_OCT: v = $urandom_range(0, 7);
      cilp_pkg::RX_DEC: v = $urandom_range(0, 9);
      default:          v = $urandom_range(0, 15);
    endcase
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
  endfunction

  // Usual lengths most of the time, lengths around the limit now and then
  function automatic int pick_len(int lo, int hi, int blo, int bhi);
    if ($urandom_range(0, 99) < 20) return $urandom_range(blo, bhi);
    return $urandom_range(lo, hi);
  endfunction

  task automatic push_prefix(cilp_pkg::radix_t r);
    case (r)
      cilp_pkg::RX_BIN: begin
        text.push_back("0");
        text.push_back($urandom_range(0, 1) ? "b" : "B");
      end
      cilp_pkg::RX_OCT: text.push_back("0");
      cilp_pkg::RX_HEX: begin
        text.push_back("0");
        text.push_back($urandom_range(0, 1) ? "x" : "X");
      end
      default: ;
    endcase
  endtask

  task automatic push_digits(cilp_pkg::radix_t r, int n);
    for (int i = 0; i < n; i++) text.push_back(digit_char(r));
  endtask

  // Build one random candidate literal into text
  task automatic make_literal();
    int               k;
    int               n;
    cilp_pkg::radix_t r;
    string            max_s;
    k = short_mode ? 200 : $urandom_range(0, 99);
    r = cilp_pkg::radix_t'($urandom_range(0, 3));
    max_s = "18446744073709551615";
    text.delete();
    if (k < 20) begin
      // decimal
      n = pick_len(1, 8, 19, 21);
      text.push_back(8'("1" + $urandom_range(0, 8)));
      push_digits(cilp_pkg::RX_DEC, n - 1);
    end else if (k < 27) begin
      // decimal around the 64-bit maximum
      for (int i = 0; i < 20; i++) text.push_back(max_s[i]);
      case ($urandom_range(0, 3))
        1: text[19] = digit_char(cilp_pkg::RX_DEC);
        2: begin
          text[18] = digit_char(cilp_pkg::RX_DEC);
          text[19] = digit_char(cilp_pkg::RX_DEC);
        end
        3: text[0] = $urandom_range(0, 1) ? "1" : "2";
        default: ;
      endcase
    end else if (k < 42) begin
      push_prefix(cilp_pkg::RX_HEX);
      push_digits(cilp_pkg::RX_HEX, pick_len(1, 8, 15, 17));
    end else if (k < 54) begin
      push_prefix(cilp_pkg::RX_BIN);
      push_digits(cilp_pkg::RX_BIN, pick_len(1, 12, 63, 66));
    end else if (k < 66) begin
      push_prefix(cilp_pkg::RX_OCT);
      push_digits(cilp_pkg::RX_OCT, pick_len(1, 8, 21, 23));
    end else if (k < 74) begin
      // hex digit outside the radix
      if (r == cilp_pkg::RX_HEX) r = cilp_pkg::RX_DEC;
      push_prefix(r);
      if (r == cilp_pkg::RX_DEC) text.push_back(8'("1" + $urandom_range(0, 8)));
      push_digits(r, $urandom_range(0, 3));
      case (r)
        cilp_pkg::RX_BIN: text.push_back(8'("2" + $urandom_range(0, 7)));
        cilp_pkg::RX_OCT: text.push_back($urandom_range(0, 1) ? 8'("8" + $urandom_range(0, 1))
                                                              : "e");
        default: text.push_back(8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 5)));
      endcase
      push_digits(r, $urandom_range(0, 2));
    end else if (k < 82) begin
      // dot inside or after the digits
      push_prefix(r);
      push_digits(r, $urandom_range(0, 3));
      text.push_back(".");
      push_digits(cilp_pkg::RX_DEC, $urandom_range(0, 2));
    end else if (k < 89) begin
      // zero forms and empty runs
      case ($urandom_range(0, 5))
        0: text.push_back("0");
        1: push_prefix(cilp_pkg::RX_HEX);
        2: push_prefix(cilp_pkg::RX_BIN);
        3: begin
          text.push_back("0");
          text.push_back(8'($urandom_range(0, 255)));
        end
        4: begin
          push_prefix($urandom_range(0, 1) ? cilp_pkg::RX_HEX : cilp_pkg::RX_BIN);
          text.push_back($urandom_range(0, 1) ? "g" : " ");
        end
        default: text.push_back($urandom_range(0, 1) ? "z" : "-");
      endcase
    end else if (k < 90) begin
      // long run, near and past the point where the digit count saturates
      if (r == cilp_pkg::RX_HEX) r = cilp_pkg::RX_BIN;
      push_prefix(r);
      if (r == cilp_pkg::RX_DEC) text.push_back("1");
      push_digits(r, $urandom_range(120, 130));
    end else if (k < 100) begin
      // noise
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      // short literals to fill the block during the hold
      push_digits(cilp_pkg::RX_DEC, $urandom_range(1, 2));
    end
    // trailing text after the digit run
    if (k < 74 && $urandom_range(0, 99) < 30) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 4))
          0: text.push_back("u");
          1: text.push_back("L");
          2: text.push_back(" ");
          3: text.push_back(";");
          default: text.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  // Main sequence
  initial begin
    int target;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero forms, empty runs, bad digit, dot, byte extremes
    set_option(1'b0);
    send_string("0");
    send_string("0x");
    send_string("0b");
    send_string("09");
    send_string("0xg");
    send_string("0b2");
    send_string("0XfF");
    send_string("0.");
    text.delete();
    text.push_back(8'hFF);
    send_text();
    text.delete();
    text.push_back(8'h00);
    send_text();
    wait_idle();
    set_option(1'b1);
    send_string("0.");
    send_string("7.");

    // Random phases, option changed between them
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0, 3:    set_option(1'b1);
        1, 4:    set_option(1'b0);
        default: set_option($urandom_range(0, 1));
      endcase
      quiet = (ph == 2);
      if (ph == 3) begin
        stall_req  = 1'b1;
        short_mode = 1'b1;
        for (int i = 0; i < 60; i++) begin
          make_literal();
          send_text();
        end
        short_mode = 1'b0;
      end
      target = 25 + (ph + 1) * ITEM_TARGET / NUM_PHASES;
      while (items_sent < target) begin
        make_literal();
        send_text();
      end
    end
    quiet = 1'b0;

    // Drain and finish
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d literals (%0d characters, %0d results checked) under %0d option writes.",
             literals_sent, items_sent, pred.results_seen, option_writes);
    $display("Covered all radixes, width limits, bad digits, dots, trailing text, %0d-cycle hold.",
             HOLD_CYCLES);
    if (pred.mismatches == 0 && pred.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[c_integer_literal_parser.f]
design/cilp_pkg.sv
design/cilp_front.sv
design/cilp_queue.sv
design/cilp_back.sv
design/c_integer_literal_parser.sv
sim/tb_c_integer_literal_parser.sv
